// File: src/cpts_pkg.sv
// Shared types, identifiers and constants of the CAN pairing transmit scheduler.
`default_nettype none
package cpts_pkg;

  // Input beat: a transmit call or a received frame
  typedef struct packed {
    logic        req_type;
    logic [31:0] now_ms;
    logic        allow_tx;
    logic [10:0] rx_id;
    logic [31:0] rx_payload;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic        tx_valid;
    logic [3:0]  tx_frame;
    logic        partner_seen;
    logic [15:0] partner_voltage;
    logic [15:0] partner_current;
    logic [31:0] partner_time;
    logic [7:0]  pairing_count;
    logic        paired;
  } out_item_t;

  // One queue entry
  typedef struct packed {
    logic [3:0] code;
    logic       ends;
  } entry_t;

  // Per-cell control
  typedef struct packed {
    logic load;
    logic shift;
    logic push;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEND,
    ST_FAST,
    ST_MID0,
    ST_MID1,
    ST_MID2,
    ST_SLOW,
    ST_DONE
  } state_t;

  localparam logic       REQ_TX = 1'b0;
  localparam logic       REQ_RX = 1'b1;

  localparam logic [1:0] CFG_PACE = 2'd0;
  localparam logic [1:0] CFG_FAST = 2'd1;
  localparam logic [1:0] CFG_MID  = 2'd2;
  localparam logic [1:0] CFG_SLOW = 2'd3;

  localparam logic [10:0] ID_MEAS   = 11'h360;
  localparam logic [10:0] ID_STAT   = 11'h3E0;
  localparam logic [10:0] ID_TIME   = 11'h420;
  localparam logic [10:0] ID_INFO0  = 11'h560;
  localparam logic [10:0] ID_INFO1  = 11'h5E0;
  localparam logic [10:0] ID_PAIR0  = 11'h5E7;
  localparam logic [10:0] ID_PAIR1  = 11'h660;

  localparam logic [3:0] FR_358 = 4'd0;
  localparam logic [3:0] FR_3D8 = 4'd1;
  localparam logic [3:0] FR_458 = 4'd2;
  localparam logic [3:0] FR_4D8 = 4'd3;
  localparam logic [3:0] FR_518 = 4'd4;

  localparam int INIT_LEN = 12;

  localparam logic [15:0] PACE_RESET = 16'd250;
  localparam logic [19:0] FAST_RESET = 20'd2000;
  localparam logic [19:0] MID_RESET  = 20'd10000;
  localparam logic [19:0] SLOW_RESET = 20'd60000;

  // Init sequence entry for queue position idx (0..11)
  function automatic entry_t init_entry(input logic [3:0] idx);
    entry_t e;
    e.ends = (idx == 4'd11);
    unique case (idx)
      4'd0:    e.code = 4'd5;
      4'd1:    e.code = 4'd6;
      4'd2:    e.code = 4'd7;
      4'd3:    e.code = 4'd8;
      4'd4:    e.code = 4'd9;
      4'd5:    e.code = 4'd10;
      4'd6:    e.code = 4'd11;
      4'd7:    e.code = 4'd0;
      4'd8:    e.code = 4'd1;
      4'd9:    e.code = 4'd2;
      4'd10:   e.code = 4'd3;
      4'd11:   e.code = 4'd4;
      default: e.code = 4'd0;
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

// File: src/can_pairing_tx_scheduler.sv
// Top level of the CAN pairing transmit scheduler: control sequencer and queue cell chain.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------
//  in      | input     | in_valid / in_stall    | in_data  (in_item_t)
//  out     | output    | out_valid / out_stall  | out_data (out_item_t)
//  cfg     | input     | cfg_write              | cfg_index, cfg_data
//
// A received frame or a transmit call without allow_tx goes from IDLE to DONE and
// back; an allowed transmit call steps through SEND, FAST, MID0..MID2, SLOW and DONE.
// The steps are set by the one shared elapsed-time subtractor, which visits the pace and the
// three period timers in turn, and by one queue write per step (three for mid).
// Reset is synchronous on rst and restores the control registers to their defaults; the
// queue cells, the item and the output payload are not cleared, only the length count.
// A stall on out holds the finished beat; the next input beat is still taken
// and worked on, and only its hand-off to the output register waits.
`default_nettype none
module can_pairing_tx_scheduler
  import cpts_pkg::*;
#(
  parameter int QUEUE_DEPTH = 20
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [19:0] cfg_data
);

  localparam int LEN_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration
  logic [15:0] pace_ms;
  logic [19:0] fast_period_ms;
  logic [19:0] mid_period_ms;
  logic [19:0] slow_period_ms;

  // Control and status
  state_t      state;
  state_t      state_next;
  in_item_t    item;
  logic [LEN_W-1:0] q_len;
  logic [31:0] last_send_time;
  logic [31:0] last_fast_time;
  logic [31:0] last_mid_time;
  logic [31:0] last_slow_time;
  logic        paired_flag;
  logic [15:0] voltage_reg;
  logic [15:0] current_reg;
  logic [31:0] time_reg;
  logic [7:0]  pairing_counter;
  logic        mid_hit;
  logic        sent;
  logic [3:0]  sent_code;
  logic        seen;

  // Datapath decisions
  logic        accept;
  logic        out_free;
  logic [31:0] sel_last;
  logic [31:0] threshold;
  logic [31:0] elapsed;
  logic        hit;
  logic        fire;
  logic        pop_en;
  logic        push_req;
  logic        push_en;
  logic [3:0]  push_code;
  logic        load_init;
  logic        rx_known;
  logic        rx_pair;

  entry_t      cells [QUEUE_DEPTH];
  entry_t      push_entry;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  // Receive decode on the input beat itself
  assign rx_pair  = (in_data.rx_id == ID_PAIR0) || (in_data.rx_id == ID_PAIR1);
  assign rx_known = rx_pair || (in_data.rx_id == ID_MEAS) || (in_data.rx_id == ID_TIME)
                 || (in_data.rx_id == ID_STAT) || (in_data.rx_id == ID_INFO0)
                 || (in_data.rx_id == ID_INFO1);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.req_type == REQ_RX || !in_data.allow_tx) state_next = ST_DONE;
          else state_next = ST_SEND;
        end
      end
      ST_SEND: state_next = ST_FAST;
      ST_FAST: state_next = ST_MID0;
      ST_MID0: state_next = ST_MID1;
      ST_MID1: state_next = ST_MID2;
      ST_MID2: state_next = ST_SLOW;
      ST_SLOW: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Shared elapsed-time check: pick the timer this step looks at
  always_comb begin
    unique case (state)
      ST_FAST: begin
        sel_last  = last_fast_time;
        threshold = {12'd0, fast_period_ms};
      end
      ST_MID0: begin
        sel_last  = last_mid_time;
        threshold = {12'd0, mid_period_ms};
      end
      ST_SLOW: begin
        sel_last  = last_slow_time;
        threshold = {12'd0, slow_period_ms};
      end
      default: begin
        sel_last  = last_send_time;
        threshold = {16'd0, pace_ms};
      end
    endcase
  end

  assign elapsed = item.now_ms - sel_last;
  assign hit     = (elapsed >= threshold);

  // Step outputs
  always_comb begin
    pop_en    = 1'b0;
    fire      = 1'b0;
    push_req  = 1'b0;
    push_code = FR_358;
    load_init = 1'b0;
    unique case (state)
      ST_IDLE: load_init = accept && (in_data.req_type == REQ_RX) && rx_pair;
      ST_SEND: pop_en = (q_len != '0) && hit;
      ST_FAST: begin
        fire      = paired_flag && hit;
        push_req  = fire;
        push_code = FR_358;
      end
      ST_MID0: begin
        fire      = paired_flag && hit;
        push_req  = fire;
        push_code = FR_518;
      end
      ST_MID1: begin
        push_req  = mid_hit;
        push_code = FR_4D8;
      end
      ST_MID2: begin
        push_req  = mid_hit;
        push_code = FR_3D8;
      end
      ST_SLOW: begin
        fire      = paired_flag && hit;
        push_req  = fire;
        push_code = FR_458;
      end
      default: ;
    endcase
  end

  // Drop the push when the queue is full
  assign push_en         = push_req && (q_len < LEN_W'(QUEUE_DEPTH));
  assign push_entry.code = push_code;
  assign push_entry.ends = 1'b0;

  // Queue cell chain: cell 0 is the head, data moves toward it on a send
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    cell_ctrl_t ctrl;
    entry_t     load_entry;
    entry_t     next_entry;

    assign ctrl.shift = pop_en;
    assign ctrl.push  = push_en && (q_len == LEN_W'(i));

    if (i < INIT_LEN) begin : g_init
      assign ctrl.load  = load_init;
      assign load_entry = init_entry(4'(i));
    end else begin : g_noinit
      assign ctrl.load  = 1'b0;
      assign load_entry = cells[i];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_entry = cells[i];
    end else begin : g_link
      assign next_entry = cells[i+1];
    end

    cpts_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .load_entry (load_entry),
      .push_entry (push_entry),
      .next_entry (next_entry),
      .entry      (cells[i])
    );
  end

  // Item payload register: hold the beat being worked on
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_data;
    end
  end

  // Control state, timers and decoded status
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      pace_ms         <= PACE_RESET;
      fast_period_ms  <= FAST_RESET;
      mid_period_ms   <= MID_RESET;
      slow_period_ms  <= SLOW_RESET;
      q_len           <= '0;
      last_send_time  <= '0;
      last_fast_time  <= '0;
      last_mid_time   <= '0;
      last_slow_time  <= '0;
      paired_flag     <= 1'b0;
      voltage_reg     <= '0;
      current_reg     <= '0;
      time_reg        <= '0;
      pairing_counter <= '0;
      mid_hit         <= 1'b0;
      sent            <= 1'b0;
      sent_code       <= '0;
      seen            <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        unique case (cfg_index)
          CFG_PACE: pace_ms        <= cfg_data[15:0];
          CFG_FAST: fast_period_ms <= cfg_data;
          CFG_MID:  mid_period_ms  <= cfg_data;
          CFG_SLOW: slow_period_ms <= cfg_data;
          default: ;
        endcase
      end

      if (accept) begin
        sent      <= 1'b0;
        sent_code <= '0;
        seen      <= (in_data.req_type == REQ_RX) && rx_known;
        if (in_data.req_type == REQ_RX) begin
          if (in_data.rx_id == ID_MEAS) begin
            voltage_reg <= in_data.rx_payload[31:16];
            current_reg <= in_data.rx_payload[15:0];
          end
          if (in_data.rx_id == ID_TIME) begin
            time_reg <= in_data.rx_payload;
          end
          if (rx_pair) begin
            pairing_counter <= pairing_counter + 8'd1;
          end
        end
      end

      // Queue length: load, pop and push never share a cycle
      priority if (load_init) begin
        q_len <= LEN_W'(INIT_LEN);
      end else if (pop_en) begin
        q_len <= q_len - LEN_W'(1);
      end else if (push_en) begin
        q_len <= q_len + LEN_W'(1);
      end

      if (pop_en) begin
        last_send_time <= item.now_ms;
        sent           <= 1'b1;
        sent_code      <= cells[0].code;
        if (cells[0].ends) paired_flag <= 1'b1;
      end

      if (fire && state == ST_FAST) last_fast_time <= item.now_ms;
      if (fire && state == ST_SLOW) last_slow_time <= item.now_ms;
      if (state == ST_MID0) begin
        mid_hit <= fire;
        if (fire) last_mid_time <= item.now_ms;
      end

      // Output register: load on hand-off, drop on the taken beat
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload: capture the status after the item
  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_data.tx_valid        <= sent;
      out_data.tx_frame        <= sent_code;
      out_data.partner_seen    <= seen;
      out_data.partner_voltage <= voltage_reg;
      out_data.partner_current <= current_reg;
      out_data.partner_time    <= time_reg;
      out_data.pairing_count   <= pairing_counter;
      out_data.paired          <= paired_flag;
    end
  end

`ifndef SYNTHESIS
  a_len_bound : assert property (@(posedge clk) disable iff (rst)
    q_len <= LEN_W'(QUEUE_DEPTH))
    else $error("queue length beyond depth");

  a_unsent_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.tx_valid |-> out_data.tx_frame == 4'd0)
    else $error("unsent beat carries a frame code");

  a_sent_not_seen : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.tx_valid |-> !out_data.partner_seen)
    else $error("sent frame and partner seen in one beat");

  a_paired_on_send : assert property (@(posedge clk) disable iff (rst)
    $rose(paired_flag) |-> $past(state) == ST_SEND)
    else $error("paired set outside a send step");

  a_no_accept_busy : assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !accept && !load_init)
    else $error("input taken while busy");
`endif

endmodule
`default_nettype wire

// File: src/cpts_cell.sv
// One queue cell: holds an entry, loads its init entry, takes its right neighbor's entry on a shift, or takes a push.
`default_nettype none
module cpts_cell
  import cpts_pkg::*;
(
  input  wire logic       clk,
  input  wire cell_ctrl_t ctrl,
  input  wire entry_t     load_entry,
  input  wire entry_t     push_entry,
  input  wire entry_t     next_entry,
  output entry_t          entry
);

  always_ff @(posedge clk) begin
    priority if (ctrl.load) begin
      entry <= load_entry;
    end else if (ctrl.shift) begin
      entry <= next_entry;
    end else if (ctrl.push) begin
      entry <= push_entry;
    end
  end

endmodule
`default_nettype wire

// File: bench/tb_can_pairing_tx_scheduler.sv
// Self-checking bench for the CAN pairing transmit scheduler: directed and random beats.
`timescale 1ns / 1ps
module tb_can_pairing_tx_scheduler;
  import cpts_pkg::*;

  localparam int QDEPTH        = 20;
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off to back the block up
  localparam int QUIET_LIMIT   = 3000;  // cycles with work outstanding and no beat moving
  localparam int SETTLE_CYCLES = 12;    // margin for an allowed transmit call to drain

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = CFG_PACE;
  logic [19:0] cfg_data  = '0;

  can_pairing_tx_scheduler #(
    .QUEUE_DEPTH(QDEPTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Beats waiting to go out on the input channel, and status beats the block owes us.
  in_item_t  calls_pending[$];
  out_item_t status_due[$];

  // Idle pressure on each side, in percent, set per phase.
  int send_idle_pct;
  int recv_idle_pct;

  // Receiver hold-off requests; the monitor counts the stretch itself.
  int holds_asked  = 0;
  int holds_served = 0;
  int hold_left    = 0;

  int error_count    = 0;
  int beats_taken    = 0;
  int results_seen   = 0;
  int frames_sent    = 0;
  int pair_requests  = 0;
  int frames_dropped = 0;
  int quiet_cycles   = 0;

  // Running millisecond clock for well-formed transmit calls.
  logic [31:0] ms_now;

  // ---------------------------------------------------------------------------
  // Scheduler shadow: register copies and the state the block keeps.
  // ---------------------------------------------------------------------------
  logic [15:0] pace_cfg;
  logic [19:0] fast_cfg, mid_cfg, slow_cfg;
  entry_t      frame_q[$];
  logic [31:0] last_send_ms, last_fast_ms, last_mid_ms, last_slow_ms;
  logic        is_paired;
  logic [15:0] volt_held, curr_held;
  logic [31:0] stamp_held;
  logic [7:0]  pair_cnt;

  // Append a frame to the transmit queue; drop it when the queue is full.
  function automatic void push_frame(input logic [3:0] code, input logic ends);
    entry_t e;
    e.code = code;
    e.ends = ends;
    if (frame_q.size() < QDEPTH) frame_q.push_back(e);
    else frames_dropped++;
  endfunction

  // Advance the shadow by one input beat and return the status beat it produces.
  function automatic out_item_t predict_status(input in_item_t c);
    out_item_t r;
    entry_t    head;
    r = '0;
    if (c.req_type == REQ_RX) begin
      // Received frame: only the partner's IDs do anything; time and allow are ignored.
      case (c.rx_id)
        ID_MEAS: begin
          r.partner_seen = 1'b1;
          volt_held = c.rx_payload[31:16];
          curr_held = c.rx_payload[15:0];
        end
        ID_TIME: begin
          r.partner_seen = 1'b1;
          stamp_held = c.rx_payload;
        end
        ID_STAT, ID_INFO0, ID_INFO1: r.partner_seen = 1'b1;
        ID_PAIR0, ID_PAIR1: begin
          // Pairing request: count it, flush the queue, load the init run.
          // The paired flag is left alone on a repeat request.
          r.partner_seen = 1'b1;
          pair_cnt = pair_cnt + 8'd1;
          pair_requests++;
          frame_q.delete();
          for (int i = 0; i < INIT_LEN; i++)
            push_frame(4'((i + 5) % INIT_LEN), i == INIT_LEN - 1);
        end
        default: ;
      endcase
    end else if (c.allow_tx) begin
      // Elapsed times are 32-bit differences, so a wrapped clock still works.
      if (frame_q.size() != 0 && (c.now_ms - last_send_ms) >= pace_cfg) begin
        head = frame_q.pop_front();
        last_send_ms = c.now_ms;
        r.tx_valid = 1'b1;
        r.tx_frame = head.code;
        frames_sent++;
        if (head.ends) is_paired = 1'b1;
      end
      // Periodic checks see the flag just set by the last init frame.
      if (is_paired) begin
        if ((c.now_ms - last_fast_ms) >= fast_cfg) begin
          last_fast_ms = c.now_ms;
          push_frame(FR_358, 1'b0);
        end
        if ((c.now_ms - last_mid_ms) >= mid_cfg) begin
          last_mid_ms = c.now_ms;
          push_frame(FR_518, 1'b0);
          push_frame(FR_4D8, 1'b0);
          push_frame(FR_3D8, 1'b0);
        end
        if ((c.now_ms - last_slow_ms) >= slow_cfg) begin
          last_slow_ms = c.now_ms;
          push_frame(FR_458, 1'b0);
        end
      end
    end
    r.partner_voltage = volt_held;
    r.partner_current = curr_held;
    r.partner_time    = stamp_held;
    r.pairing_count   = pair_cnt;
    r.paired          = is_paired;
    return r;
  endfunction

  // Log the first few failures in full; count the rest.
  function automatic void flag_error(input string what, input logic [31:0] want,
                                     input logic [31:0] got);
    error_count++;
    if (error_count <= 10)
      $display("ERROR at result %0d, %s: expected %0h, actual %0h",
               results_seen, what, want, got);
  endfunction

  // Beat builders; the fields the block ignores get random values.
  function automatic in_item_t tx_call(input logic [31:0] now, input logic allow);
    in_item_t c;
    c.req_type   = REQ_TX;
    c.now_ms     = now;
    c.allow_tx   = allow;
    c.rx_id      = 11'($urandom_range(0, 2047));
    c.rx_payload = $urandom();
    return c;
  endfunction

  function automatic in_item_t rx_beat(input logic [10:0] id, input logic [31:0] payload);
    in_item_t c;
    c.req_type   = REQ_RX;
    c.now_ms     = $urandom();
    c.allow_tx   = 1'($urandom_range(0, 1));
    c.rx_id      = id;
    c.rx_payload = payload;
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: score the beat taken at this edge, then offer the next one.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        status_due.push_back(predict_status(in_data));
        beats_taken++;
      end
      // Hold a stalled beat as it is; only refill once the slot is free.
      if (!in_valid || !in_stall) begin
        if (calls_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data  <= calls_pending.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each status beat with the oldest expectation, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (status_due.size() == 0) begin
          flag_error("status beats expected", 32'd0, 32'd1);
        end else begin
          want = status_due.pop_front();
          if (out_data.tx_valid !== want.tx_valid)
            flag_error("tx_valid", 32'(want.tx_valid), 32'(out_data.tx_valid));
          if (out_data.tx_frame !== want.tx_frame)
            flag_error("tx_frame", 32'(want.tx_frame), 32'(out_data.tx_frame));
          if (out_data.partner_seen !== want.partner_seen)
            flag_error("partner_seen", 32'(want.partner_seen), 32'(out_data.partner_seen));
          if (out_data.partner_voltage !== want.partner_voltage)
            flag_error("partner_voltage", 32'(want.partner_voltage),
                       32'(out_data.partner_voltage));
          if (out_data.partner_current !== want.partner_current)
            flag_error("partner_current", 32'(want.partner_current),
                       32'(out_data.partner_current));
          if (out_data.partner_time !== want.partner_time)
            flag_error("partner_time", want.partner_time, out_data.partner_time);
          if (out_data.pairing_count !== want.pairing_count)
            flag_error("pairing_count", 32'(want.pairing_count), 32'(out_data.pairing_count));
          if (out_data.paired !== want.paired)
            flag_error("paired", 32'(want.paired), 32'(out_data.paired));
        end
      end
      // A new hold-off request starts a long stall; otherwise stall at random.
      if (holds_served != holds_asked) begin
        holds_served <= holds_asked;
        hold_left    <= HOLD_CYCLES;
        out_stall    <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Watchdog: end the run if work is outstanding and no beat moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (calls_pending.size() == 0 && !in_valid && status_due.size() == 0)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no beat moved for %0d cycles", QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Wait until every beat is in and every result is out, then let the block drain.
  task automatic settle();
    @(negedge clk);
    while (calls_pending.size() != 0 || in_valid || status_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register; the block is idle whenever this runs.
  task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_PACE: pace_cfg = val[15:0];
      CFG_FAST: fast_cfg = val;
      CFG_MID:  mid_cfg  = val;
      CFG_SLOW: slow_cfg = val;
      default: ;
    endcase
  endtask

  // One random phase: mostly transmit calls on an advancing clock, partner
  // frames and the odd pairing request, with some noise IDs, blocked calls
  // and time jumps mixed in.
  task automatic run_phase(input int n_calls, input int send_pct, input int recv_pct,
                           input bit squeeze);
    int unsigned pick;
    logic [31:0] advance_ms;
    logic [10:0] id;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    // Open with a pairing request so the init run and periodic frames get going.
    calls_pending.push_back(rx_beat(ID_PAIR0, $urandom()));
    repeat (n_calls) begin
      pick = $urandom_range(0, 199);
      if (pick < 3) begin
        calls_pending.push_back(rx_beat(pick[0] ? ID_PAIR1 : ID_PAIR0, $urandom()));
      end else if (pick < 40) begin
        case ($urandom_range(0, 4))
          0:       id = ID_MEAS;
          1:       id = ID_TIME;
          2:       id = ID_STAT;
          3:       id = ID_INFO0;
          default: id = ID_INFO1;
        endcase
        calls_pending.push_back(rx_beat(id, $urandom()));
      end else if (pick < 55) begin
        id = 11'($urandom_range(0, 2047));
        calls_pending.push_back(rx_beat(id, $urandom()));
      end else if (pick < 65) begin
        calls_pending.push_back(tx_call($urandom(), 1'b0));
      end else if (pick < 72) begin
        // Jump the clock anywhere, near-wrap values included.
        ms_now = $urandom();
        calls_pending.push_back(tx_call(ms_now, 1'b1));
      end else begin
        // Steps scaled to the pace and the fast and slow periods so every timer trips now and then.
        case ($urandom_range(0, 9))
          0:             advance_ms = 32'd0;
          1, 2, 3, 4, 5: advance_ms = $urandom_range(0, 2 * pace_cfg + 1);
          6, 7, 8:       advance_ms = $urandom_range(0, 2 * fast_cfg + 1);
          default:       advance_ms = $urandom_range(0, 2 * slow_cfg + 1);
        endcase
        ms_now = ms_now + advance_ms;
        calls_pending.push_back(tx_call(ms_now, 1'b1));
      end
    end
    // Stall the receiver for a long stretch while the sender keeps pushing.
    if (squeeze) holds_asked++;
    settle();
  endtask

  initial begin
    // Shadow starts from the reset values of the block.
    pace_cfg     = PACE_RESET;
    fast_cfg     = FAST_RESET;
    mid_cfg      = MID_RESET;
    slow_cfg     = SLOW_RESET;
    frame_q.delete();
    last_send_ms = '0;
    last_fast_ms = '0;
    last_mid_ms  = '0;
    last_slow_ms = '0;
    is_paired    = 1'b0;
    volt_held    = '0;
    curr_held    = '0;
    stamp_held   = '0;
    pair_cnt     = '0;
    send_idle_pct = 10;
    recv_idle_pct = 78;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part, default timing (pace 250, fast period 2000).
    calls_pending.push_back(tx_call(32'd0, 1'b1));              // empty queue: no send
    calls_pending.push_back(rx_beat(ID_MEAS, 32'hFFFF_FFFF));   // voltage and current at max
    calls_pending.push_back(rx_beat(ID_TIME, 32'h8000_0001));
    calls_pending.push_back(rx_beat(ID_STAT, $urandom()));
    calls_pending.push_back(rx_beat(ID_INFO0, $urandom()));
    calls_pending.push_back(rx_beat(ID_INFO1, $urandom()));
    calls_pending.push_back(rx_beat(11'h7FF, 32'hFFFF_FFFF));   // foreign ID: no effect
    calls_pending.push_back(tx_call(32'hFFFF_FFFF, 1'b0));      // not allowed: no effect
    calls_pending.push_back(rx_beat(ID_PAIR0, $urandom()));     // load the init run
    calls_pending.push_back(tx_call(32'd100, 1'b1));            // under the pace: hold
    // Drain the whole init run at the pace; the last send pairs and, in the
    // same call, trips the fast timer.
    for (int k = 1; k <= INIT_LEN; k++)
      calls_pending.push_back(tx_call(250 * k, 1'b1));
    calls_pending.push_back(rx_beat(ID_PAIR1, $urandom()));     // repeat pairing, stays paired
    calls_pending.push_back(tx_call(32'hFFFF_FF00, 1'b1));
    calls_pending.push_back(tx_call(32'h0000_0050, 1'b1));      // elapsed time across the wrap
    ms_now = 32'h0000_0050;
    settle();

    // Fast timing: queue fills and periodic frames get dropped.
    write_reg(CFG_PACE, 20'd1);
    write_reg(CFG_FAST, 20'd5);
    write_reg(CFG_MID, 20'd20);
    write_reg(CFG_SLOW, 20'd60);
    run_phase(350, 10, 78, 1'b0);

    // Slow timing (pace at its 16-bit maximum), idle pressure swapped.
    write_reg(CFG_PACE, 20'd65535);
    write_reg(CFG_FAST, 20'd1000000);
    write_reg(CFG_MID, 20'd1000000);
    write_reg(CFG_SLOW, 20'd1000000);
    run_phase(250, 78, 10, 1'b0);

    // Zero pace and periods: everything fires on each allowed call. No idling,
    // plus one long receiver hold-off.
    write_reg(CFG_PACE, 20'd0);
    write_reg(CFG_FAST, 20'd0);
    write_reg(CFG_MID, 20'd0);
    write_reg(CFG_SLOW, 20'd0);
    run_phase(200, 0, 0, 1'b1);

    // One random timing set.
    write_reg(CFG_PACE, 20'($urandom_range(1, 400)));
    write_reg(CFG_FAST, 20'($urandom_range(1, 3000)));
    write_reg(CFG_MID, 20'($urandom_range(1, 10000)));
    write_reg(CFG_SLOW, 20'($urandom_range(1, 30000)));
    run_phase(250, 0, 0, 1'b0);

    if (status_due.size() != 0)
      flag_error("status beats left over", 32'd0, 32'(status_due.size()));

    $display("Run summary: %0d beats in, %0d status beats checked, %0d frames sent,",
             beats_taken, results_seen, frames_sent);
    $display("  %0d pairing requests, %0d periodic frames dropped on a full queue, %0d errors",
             pair_requests, frames_dropped, error_count);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
src/cpts_pkg.sv
src/cpts_cell.sv
src/can_pairing_tx_scheduler.sv
bench/tb_can_pairing_tx_scheduler.sv
